// ===== rtl/salru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types, sizes and codes of the set-associative LRU tag store model.
// ----------------------------------------------------------------------------
package salru_pkg;

  // store geometry
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int TAG_WIDTH    = 32;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;

  localparam int SET_W      = MAX_SET_BITS;
  localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W     = WAY_W;
  localparam int WAYS_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int SB_W       = $clog2(MAX_SET_BITS + 1);

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  // fixed register and field widths
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int SHIFT_W      = BLOCK_BITS_W + 1;
  localparam int ADDR_W       = 64;
  localparam int TOTAL_W      = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  // request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  // access actions
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STORE  = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_FETCH  = 2'd3;

  // lookup outcomes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // one line of the store
  typedef struct packed {
    logic                 valid;
    logic [TAG_WIDTH-1:0] tag;
    logic [RANK_W-1:0]    rank;
  } line_t;

  localparam int LINE_W = $bits(line_t);
  localparam int ROW_W  = LINE_W * MAX_WAYS;

  // all ways of one set
  typedef line_t [MAX_WAYS-1:0] row_t;

  // effective configuration
  typedef struct packed {
    logic [SB_W-1:0]         set_bits;
    logic [WAYS_CNT_W-1:0]   ways;
    logic [BLOCK_BITS_W-1:0] block_bits;
  } cfg_t;

  // classified lookup request
  typedef struct packed {
    logic [SET_W-1:0]     set;
    logic [TAG_WIDTH-1:0] tag;
    logic                 modify;
  } req_t;

endpackage

// ===== rtl/set_assoc_cache_lru_sim.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag store of a set-associative cache with LRU replacement and hit, miss
// and eviction totals.
// ----------------------------------------------------------------------------
// An access is taken at a clock edge with start high and busy low; a
// two-entry request queue lets start be taken while earlier lookups are
// still at work, and busy rises only when that queue is full. Instruction
// fetches are taken and give no result. Each lookup gives one result, shown
// for exactly one cycle with result_valid high; there is no way to hold it
// off. A load or store gives one result, a modify gives two on consecutive
// cycles, the second flagged with last. Every lookup passes through the
// store in order: read the set row, choose the way, write the row back;
// a modify then gives its second result. The next request leaves the
// queue only once the lookup before it is through. The store is empty
// right after reset with no clearing pass (a flag per set marks rows written
// since reset). Configuration writes are always taken and must only be made
// while no access is in flight.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           action,
  input  logic [salru_pkg::ADDR_W-1:0]         address,
  output logic                                 result_valid,
  output logic [1:0]                           outcome,
  output logic                                 last,
  output logic [salru_pkg::TOTAL_W-1:0]        hit_total,
  output logic [salru_pkg::TOTAL_W-1:0]        miss_total,
  output logic [salru_pkg::TOTAL_W-1:0]        eviction_total,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [salru_pkg::SET_BITS_W-1:0]   set_bits;
  logic [salru_pkg::WAYS_W-1:0]       ways_in_use;
  logic [salru_pkg::BLOCK_BITS_W-1:0] block_bits;
  salru_pkg::cfg_t                    cfg;

  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            q_full;
  salru_pkg::req_t q_req;
  salru_pkg::req_t q_head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      ways_in_use <= salru_pkg::WAYS_W'(1);
      block_bits  <= salru_pkg::BLOCK_BITS_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        salru_pkg::CFG_SET_BITS:   set_bits    <= cfg_data[salru_pkg::SET_BITS_W-1:0];
        salru_pkg::CFG_WAYS:       ways_in_use <= cfg_data[salru_pkg::WAYS_W-1:0];
        salru_pkg::CFG_BLOCK_BITS: block_bits  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // clamp to the built store
  always_comb begin
    if (int'(set_bits) > salru_pkg::MAX_SET_BITS) begin
      cfg.set_bits = salru_pkg::SB_W'(salru_pkg::MAX_SET_BITS);
    end else begin
      cfg.set_bits = salru_pkg::SB_W'(set_bits);
    end
    if (ways_in_use == '0) begin
      cfg.ways = salru_pkg::WAYS_CNT_W'(1);
    end else if (int'(ways_in_use) > salru_pkg::MAX_WAYS) begin
      cfg.ways = salru_pkg::WAYS_CNT_W'(salru_pkg::MAX_WAYS);
    end else begin
      cfg.ways = salru_pkg::WAYS_CNT_W'(ways_in_use);
    end
    cfg.block_bits = block_bits;
  end

  // access intake and address split
  salru_front u_front (
    .start   (start),
    .busy    (busy),
    .action  (action),
    .address (address),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_req   (q_req)
  );

  // request queue
  salru_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (q_req),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // lookup engine and store
  salru_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .result_valid   (result_valid),
    .outcome        (outcome),
    .last           (last),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

endmodule

// ===== rtl/salru_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/salru_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_front
// Takes accesses, drops instruction fetches, splits the address into set
// and tag and pushes the lookup request into the queue.
// ----------------------------------------------------------------------------
module salru_front (
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       action,
  input  logic [salru_pkg::ADDR_W-1:0]     address,
  input  salru_pkg::cfg_t                  cfg,
  input  logic                             q_full,
  output logic                             q_push,
  output salru_pkg::req_t                  q_req
);

  logic [salru_pkg::ADDR_W-1:0]  set_shifted;
  logic [salru_pkg::ADDR_W-1:0]  tag_shifted;
  logic [salru_pkg::SHIFT_W-1:0] tag_shift;
  logic [salru_pkg::SET_W-1:0]   set_mask;

  // request accepted whenever the queue has room
  assign busy   = q_full;
  assign q_push = start && !q_full && (action != salru_pkg::ACT_FETCH);

  // address split
  assign tag_shift   = salru_pkg::SHIFT_W'(cfg.set_bits) + salru_pkg::SHIFT_W'(cfg.block_bits);
  assign set_shifted = address >> cfg.block_bits;
  assign tag_shifted = address >> tag_shift;
  assign set_mask    = ~({salru_pkg::SET_W{1'b1}} << cfg.set_bits);

  assign q_req.set    = set_shifted[salru_pkg::SET_W-1:0] & set_mask;
  assign q_req.tag    = tag_shifted[salru_pkg::TAG_WIDTH-1:0];
  assign q_req.modify = (action == salru_pkg::ACT_MODIFY);

endmodule

// ===== rtl/salru_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_queue
// Short first-in first-out queue of lookup requests between front and back.
// ----------------------------------------------------------------------------
module salru_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  salru_pkg::req_t push_req,
  input  logic            pop,
  output salru_pkg::req_t head,
  output logic            empty,
  output logic            full
);

  salru_pkg::req_t                 entries [salru_pkg::Q_DEPTH];
  logic [salru_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [salru_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [salru_pkg::Q_CNT_W-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == salru_pkg::Q_CNT_W'(salru_pkg::Q_DEPTH));
  assign head  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

// ===== rtl/salru_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_back
// Carries out lookups: reads a set row, picks the hit, free or victim way,
// ages the other ways, writes the row back and reports the outcome.
// ----------------------------------------------------------------------------
module salru_back (
  input  logic                              clk,
  input  logic                              rst,
  input  salru_pkg::cfg_t                   cfg,
  input  logic                              q_empty,
  input  salru_pkg::req_t                   q_head,
  output logic                              q_pop,
  output logic                              result_valid,
  output logic [1:0]                        outcome,
  output logic                              last,
  output logic [salru_pkg::TOTAL_W-1:0]     hit_total,
  output logic [salru_pkg::TOTAL_W-1:0]     miss_total,
  output logic [salru_pkg::TOTAL_W-1:0]     eviction_total
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_UPDATE, S_SECOND} state_t;

  state_t                            state;
  salru_pkg::req_t                   req;
  salru_pkg::row_t                   row_q;
  logic [salru_pkg::WAY_W-1:0]       sel_way;
  logic [1:0]                        sel_outcome;
  logic [salru_pkg::NUM_SETS-1:0]    row_valid;
  logic [salru_pkg::TOTAL_W-1:0]     hit_cnt;
  logic [salru_pkg::TOTAL_W-1:0]     miss_cnt;
  logic [salru_pkg::TOTAL_W-1:0]     evict_cnt;

  logic [salru_pkg::ROW_W-1:0]       rd_data;
  salru_pkg::row_t                   row_cur;
  salru_pkg::row_t                   row_next;

  logic                              hit_found;
  logic                              free_found;
  logic [salru_pkg::WAY_W-1:0]       hit_way;
  logic [salru_pkg::WAY_W-1:0]       free_way;
  logic [salru_pkg::WAY_W-1:0]       victim_way;
  logic [salru_pkg::RANK_W-1:0]      best_rank;
  logic [salru_pkg::WAY_W-1:0]       eval_way;
  logic [1:0]                        eval_outcome;

  logic                              was_valid;
  logic [salru_pkg::RANK_W-1:0]      old_rank;
  logic [salru_pkg::TOTAL_W-1:0]     hit_cnt_next;
  logic [salru_pkg::TOTAL_W-1:0]     miss_cnt_next;
  logic [salru_pkg::TOTAL_W-1:0]     evict_cnt_next;

  // take the next request only when the row port is free
  assign q_pop = (state == S_IDLE) && !q_empty;

  // set rows, one read and one write a cycle
  salru_ram #(
    .WIDTH (salru_pkg::ROW_W),
    .DEPTH (salru_pkg::NUM_SETS)
  ) u_store (
    .clk   (clk),
    .we    (state == S_UPDATE),
    .waddr (req.set),
    .wdata (row_next),
    .raddr (q_head.set),
    .rdata (rd_data)
  );

  // a row never written since reset reads as empty
  assign row_cur = row_valid[req.set] ? salru_pkg::row_t'(rd_data) : '0;

  // way search: first matching way, first free way, oldest way
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    victim_way = '0;
    best_rank  = '0;
    for (int i = 0; i < salru_pkg::MAX_WAYS; i++) begin
      if (i < int'(cfg.ways)) begin
        if (row_cur[i].valid && (row_cur[i].tag == req.tag) && !hit_found) begin
          hit_found = 1'b1;
          hit_way   = salru_pkg::WAY_W'(i);
        end
        if (!row_cur[i].valid && !free_found) begin
          free_found = 1'b1;
          free_way   = salru_pkg::WAY_W'(i);
        end
        if (row_cur[i].rank > best_rank) begin
          best_rank  = row_cur[i].rank;
          victim_way = salru_pkg::WAY_W'(i);
        end
      end
    end
    if (hit_found) begin
      eval_way     = hit_way;
      eval_outcome = salru_pkg::OUT_HIT;
    end else if (free_found) begin
      eval_way     = free_way;
      eval_outcome = salru_pkg::OUT_MISS;
    end else begin
      eval_way     = victim_way;
      eval_outcome = salru_pkg::OUT_EVICT;
    end
  end

  // age the other in-use ways and refresh the chosen one
  always_comb begin
    was_valid = row_q[sel_way].valid;
    old_rank  = row_q[sel_way].rank;
    row_next  = row_q;
    for (int i = 0; i < salru_pkg::MAX_WAYS; i++) begin
      if ((i < int'(cfg.ways)) && (salru_pkg::WAY_W'(i) != sel_way) && row_q[i].valid) begin
        if ((!was_valid || (row_q[i].rank < old_rank)) &&
            (row_q[i].rank < salru_pkg::RANK_MAX)) begin
          row_next[i].rank = row_q[i].rank + 1'b1;
        end
      end
    end
    row_next[sel_way].valid = 1'b1;
    row_next[sel_way].tag   = req.tag;
    row_next[sel_way].rank  = '0;
  end

  // running totals after this lookup
  assign hit_cnt_next   = hit_cnt + salru_pkg::TOTAL_W'(sel_outcome == salru_pkg::OUT_HIT);
  assign miss_cnt_next  = miss_cnt + salru_pkg::TOTAL_W'(sel_outcome != salru_pkg::OUT_HIT);
  assign evict_cnt_next = evict_cnt + salru_pkg::TOTAL_W'(sel_outcome == salru_pkg::OUT_EVICT);

  // sequencer, store bookkeeping and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_valid    <= '0;
      hit_cnt      <= '0;
      miss_cnt     <= '0;
      evict_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            req   <= q_head;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          row_q       <= row_cur;
          sel_way     <= eval_way;
          sel_outcome <= eval_outcome;
          state       <= S_UPDATE;
        end
        S_UPDATE: begin
          row_valid[req.set] <= 1'b1;
          hit_cnt            <= hit_cnt_next;
          miss_cnt           <= miss_cnt_next;
          evict_cnt          <= evict_cnt_next;
          result_valid       <= 1'b1;
          outcome            <= sel_outcome;
          last               <= !req.modify;
          hit_total          <= hit_cnt_next;
          miss_total         <= miss_cnt_next;
          eviction_total     <= evict_cnt_next;
          state              <= req.modify ? S_SECOND : S_IDLE;
        end
        S_SECOND: begin
          // second lookup of a modify finds the line just used at rank zero
          hit_cnt        <= hit_cnt + 1'b1;
          result_valid   <= 1'b1;
          outcome        <= salru_pkg::OUT_HIT;
          last           <= 1'b1;
          hit_total      <= hit_cnt + 1'b1;
          miss_total     <= miss_cnt;
          eviction_total <= evict_cnt;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/salru_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_checker
// Port-level checks of result sequencing and running totals.
// ----------------------------------------------------------------------------
module salru_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              result_valid,
  input logic [1:0]                        outcome,
  input logic                              last,
  input logic [salru_pkg::TOTAL_W-1:0]     hit_total,
  input logic [salru_pkg::TOTAL_W-1:0]     miss_total,
  input logic [salru_pkg::TOTAL_W-1:0]     eviction_total
);

  logic [salru_pkg::TOTAL_W-1:0] seen_hits;
  logic [salru_pkg::TOTAL_W-1:0] seen_misses;
  logic [salru_pkg::TOTAL_W-1:0] seen_evicts;

  // totals as last reported
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_hits   <= '0;
      seen_misses <= '0;
      seen_evicts <= '0;
    end else if (result_valid) begin
      seen_hits   <= hit_total;
      seen_misses <= miss_total;
      seen_evicts <= eviction_total;
    end
  end

  // no result in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result reported right after reset");

  // first lookup of a modify is followed at once by a final hit
  a_modify_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid && last && (outcome == salru_pkg::OUT_HIT))
    else $error("modify second lookup missing or not a hit");

  // hit total steps by one exactly on a hit
  a_hit_total: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      hit_total == seen_hits + salru_pkg::TOTAL_W'(outcome == salru_pkg::OUT_HIT))
    else $error("hit total out of step with outcomes");

  // miss and eviction totals follow the outcome
  a_miss_totals: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (miss_total == seen_misses + salru_pkg::TOTAL_W'(outcome != salru_pkg::OUT_HIT)) &&
      (eviction_total == seen_evicts + salru_pkg::TOTAL_W'(outcome == salru_pkg::OUT_EVICT)))
    else $error("miss or eviction total out of step with outcomes");

endmodule

bind set_assoc_cache_lru_sim salru_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .outcome        (outcome),
  .last           (last),
  .hit_total      (hit_total),
  .miss_total     (miss_total),
  .eviction_total (eviction_total)
);

// ===== bench/tb_set_assoc_cache_lru_sim.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_sim
// Self-checking bench for the set-associative LRU tag store. A tracker class
// keeps its own copy of the lines, age ranks, totals and geometry registers,
// predicts every lookup result of each accepted request, and compares the
// results field by field in order. Stimulus is a short directed part followed
// by random phases over several geometries, with random sender gaps.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_sim;
  import salru_pkg::*;

  localparam int LINES       = NUM_SETS * MAX_WAYS;
  localparam int POOL_SIZE   = 10;
  localparam int PHASE_ITEMS = 175;
  localparam int SETTLE      = 24;
  localparam int STALL_LIMIT = 2000;

  // one predicted lookup result
  typedef struct {
    logic [1:0]         outcome;
    logic               last;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evictions;
  } lookup_result_t;

  // shadow tag store and ordered list of expected lookup results
  class lru_tag_tracker;
    logic                 line_valid [LINES];
    logic [TAG_WIDTH-1:0] line_tag   [LINES];
    logic [RANK_W-1:0]    line_rank  [LINES];
    logic [TOTAL_W-1:0]   hits, misses, evictions;
    int unsigned          set_bits, ways_in_use, block_bits;
    lookup_result_t       pending_results [$];
    int                   errors;

    function new();
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_rank[i]  = '0;
      end
      hits        = '0;
      misses      = '0;
      evictions   = '0;
      set_bits    = 0;
      ways_in_use = 1;
      block_bits  = 4;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SET_BITS:   set_bits    = data[2:0];
        CFG_WAYS:       ways_in_use = data[3:0];
        CFG_BLOCK_BITS: block_bits  = data;
        default: ;
      endcase
    endfunction

    // move a line to most recent, aging the lines it passes
    function void promote_line(int base, int ways, int w, logic [TAG_WIDTH-1:0] t);
      logic              was_valid;
      logic [RANK_W-1:0] old_rank;
      int                i, k;
      was_valid = line_valid[base + w];
      old_rank  = line_rank[base + w];
      for (i = 0; i < ways; i++) begin
        k = base + i;
        if (i != w && line_valid[k]) begin
          if ((!was_valid || line_rank[k] < old_rank) && line_rank[k] < RANK_MAX)
            line_rank[k]++;
        end
      end
      line_valid[base + w] = 1'b1;
      line_tag[base + w]   = t;
      line_rank[base + w]  = '0;
    endfunction

    // one lookup in a set: hit, fill a free way or evict the oldest
    function void probe_set(int set_idx, logic [TAG_WIDTH-1:0] t, logic is_last);
      int                ways, base, hit_way, free_way, victim, i;
      logic [RANK_W-1:0] top;
      lookup_result_t    r;
      ways     = (ways_in_use == 0) ? 1 :
                 ((ways_in_use > MAX_WAYS) ? MAX_WAYS : ways_in_use);
      base     = set_idx * MAX_WAYS;
      hit_way  = -1;
      free_way = -1;
      for (i = 0; i < ways; i++) begin
        if (line_valid[base + i] && line_tag[base + i] == t) begin
          hit_way = i;
          break;
        end
        if (!line_valid[base + i] && free_way < 0) free_way = i;
      end
      if (hit_way >= 0) begin
        hits++;
        r.outcome = OUT_HIT;
        promote_line(base, ways, hit_way, t);
      end else if (free_way >= 0) begin
        misses++;
        r.outcome = OUT_MISS;
        promote_line(base, ways, free_way, t);
      end else begin
        misses++;
        evictions++;
        victim = 0;
        top    = '0;
        for (i = 0; i < ways; i++) begin
          if (line_rank[base + i] > top) begin
            top    = line_rank[base + i];
            victim = i;
          end
        end
        r.outcome = OUT_EVICT;
        promote_line(base, ways, victim, t);
      end
      r.last      = is_last;
      r.hits      = hits;
      r.misses    = misses;
      r.evictions = evictions;
      pending_results.push_back(r);
    endfunction

    // split the address and predict the lookups of one accepted request
    function void note_request(logic [1:0] act, logic [ADDR_W-1:0] addr);
      int unsigned          sbe;
      int                   set_idx;
      logic [ADDR_W-1:0]    down;
      logic [TAG_WIDTH-1:0] t;
      if (act == ACT_FETCH) return;
      sbe     = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
      set_idx = int'((addr >> block_bits) & ((64'd1 << sbe) - 64'd1));
      down    = (sbe + block_bits >= ADDR_W) ? '0 : (addr >> (sbe + block_bits));
      t       = down[TAG_WIDTH-1:0];
      if (act == ACT_MODIFY) begin
        probe_set(set_idx, t, 1'b0);
        probe_set(set_idx, t, 1'b1);
      end else begin
        probe_set(set_idx, t, 1'b1);
      end
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] oc, logic lst, logic [TOTAL_W-1:0] h,
                               logic [TOTAL_W-1:0] m, logic [TOTAL_W-1:0] e);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: outcome %0d", oc);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("outcome", want.outcome, oc);
      compare_field("last", want.last, lst);
      compare_field("hit_total", want.hits, h);
      compare_field("miss_total", want.misses, m);
      compare_field("eviction_total", want.evictions, e);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            action = ACT_LOAD;
  logic [ADDR_W-1:0]     address = '0;
  logic                  result_valid;
  logic [1:0]            outcome;
  logic                  last;
  logic [TOTAL_W-1:0]    hit_total, miss_total, eviction_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lru_tag_tracker        tracker = new();
  logic [TAG_WIDTH-1:0]  tag_pool [POOL_SIZE];
  bit                    idle_on = 1'b1;
  int unsigned           cur_sbe = 0;
  int unsigned           cur_bb = 4;
  int                    stall_cycles = 0;

  set_assoc_cache_lru_sim u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .address        (address),
    .result_valid   (result_valid),
    .outcome        (outcome),
    .last           (last),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock, period 8 ns
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // check results, then note accepted requests and register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid)
        tracker.check_result(outcome, last, hit_total, miss_total, eviction_total);
      if (start && !busy) tracker.note_request(action, address);
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // present one request, idling each cycle before it at random
  task automatic send_request(logic [1:0] act, logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(0, 99) < 21) gap++;
    end
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    action  <= act;
    address <= addr;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and wait until every predicted result is back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg_port(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reprogram geometry once the block is idle
  task automatic set_geometry(int unsigned sb, int unsigned ways, int unsigned bb);
    drain_results();
    write_reg_port(CFG_SET_BITS, CFG_DATA_W'(sb));
    write_reg_port(CFG_WAYS, CFG_DATA_W'(ways));
    write_reg_port(CFG_BLOCK_BITS, CFG_DATA_W'(bb));
    cur_sbe = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
    cur_bb  = bb;
  endtask

  // mostly pooled tags in a few sets so lines get reused; some fully random
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] tag_part, set_part, off, hi;
    int unsigned       sh;
    if ($urandom_range(0, 99) < 15) return {$urandom, $urandom};
    sh       = cur_sbe + cur_bb;
    tag_part = 64'(tag_pool[$urandom_range(0, POOL_SIZE - 1)]);
    set_part = 64'($urandom_range(0, 3)) & ((64'd1 << cur_sbe) - 64'd1);
    off      = {$urandom, $urandom} & ((64'd1 << cur_bb) - 64'd1);
    hi       = {$urandom, $urandom};
    return (hi << (sh + 32)) | (tag_part << sh) | (set_part << cur_bb) | off;
  endfunction

  task automatic random_phase(int unsigned sb, int unsigned ways, int unsigned bb,
                              bit calm, int pause_at);
    int         n;
    logic [1:0] act;
    set_geometry(sb, ways, bb);
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    idle_on = !calm;
    n = 0;
    while (n < PHASE_ITEMS) begin
      act = 2'($urandom_range(0, 3));
      send_request(act, pick_address());
      n++;
      if (n == pause_at) drain_results();
    end
    idle_on = 1'b1;
  endtask

  int unsigned sb_list   [6] = '{0, 6, 2, 1, 3, 7};
  int unsigned ways_list [6] = '{1, 8, 4, 8, 2, 9};
  int unsigned bb_list   [6] = '{0, 32, 4, 6, 10, 63};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every action, hit, fill, eviction and address extremes
    set_geometry(1, 2, 4);
    send_request(ACT_LOAD, 64'h0);
    send_request(ACT_STORE, 64'h0);
    send_request(ACT_MODIFY, 64'h100);
    send_request(ACT_FETCH, 64'h200);
    send_request(ACT_LOAD, 64'h200);
    send_request(ACT_LOAD, 64'h10);
    send_request(ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_LOAD, 64'h8000_0000_0000_0000);
    send_request(ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_FETCH, 64'hFFFF_FFFF_FFFF_FFFF);

    // oversized set bits, too many ways, tag shifted out entirely
    set_geometry(7, 15, 63);
    send_request(ACT_LOAD, 64'h0);
    send_request(ACT_LOAD, 64'h8000_0000_0000_0000);
    send_request(ACT_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);

    // zero ways behaves as direct mapped
    set_geometry(0, 0, 0);
    send_request(ACT_LOAD, 64'h5);
    send_request(ACT_LOAD, 64'h6);
    send_request(ACT_LOAD, 64'h5);

    // same tag left in two ways by geometry changes; lowest way must hit
    set_geometry(6, 1, 0);
    send_request(ACT_LOAD, 64'h7F);
    set_geometry(6, 2, 0);
    send_request(ACT_LOAD, 64'hBF);
    set_geometry(6, 1, 0);
    send_request(ACT_LOAD, 64'hBF);
    set_geometry(6, 2, 0);
    send_request(ACT_LOAD, 64'hBF);

    // random phases: fixed corner geometries, then random ones
    for (int p = 0; p < 6; p++)
      random_phase(sb_list[p], ways_list[p], bb_list[p], p == 1, (p == 3) ? 80 : -1);
    for (int p = 0; p < 4; p++)
      random_phase($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 40),
                   1'b0, -1);

    drain_results();
    if (tracker.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
